// ===== sv/dstq_pkg.sv =====
// Shared types and constants for the deadline-sorted timer queue.
// Holds the entry word, the per-cell command set, request and status codes.
// No dependencies.
package dstq_pkg;

  localparam int DL_W   = 48;
  localparam int ID_W   = 16;
  localparam int DEST_W = 4;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 3;
  localparam int OCC_W  = 5;
  // most entries a single tick may pop
  localparam int MAXOUT = 16;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EXPIRED   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NONE_DUE  = 3'd4;

  typedef struct packed {
    logic [DL_W-1:0]   deadline;
    logic [ID_W-1:0]   id;
    logic [DEST_W-1:0] dest;
    logic              kind;
    logic              lost;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_POP    = 2'd3
  } cmd_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cmd_e            cmd;
    logic [DL_W-1:0] key;
    entry_t          entry;
  } ctl_t;

endpackage

// ===== sv/dstq_cell.sv =====
// One slot of the sorted chain: holds an entry and compares it to the key.
// Takes its neighbor's entry to open or close a gap. Depends on dstq_pkg.
module dstq_cell (
  input  logic            clk_i,
  input  dstq_pkg::ctl_t  ctl_i,
  input  logic            occupied_i,
  input  logic            le_prev_i,
  input  logic            hit_prev_i,
  input  dstq_pkg::entry_t left_i,
  input  dstq_pkg::entry_t right_i,
  output dstq_pkg::entry_t entry_o,
  output logic            le_o,
  output logic            hit_o
);
  import dstq_pkg::*;

  entry_t entry_q, entry_d;
  logic   match;

  assign le_o    = occupied_i && (entry_q.deadline <= ctl_i.key);
  assign match   = occupied_i && entry_q.kind && (entry_q.dest == ctl_i.entry.dest);
  assign hit_o   = hit_prev_i || match;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.cmd)
      CMD_INSERT: begin
        // open the gap behind the last entry due at or before the new one
        if (!le_prev_i) begin
          entry_d = left_i;
        end else if (!le_o) begin
          entry_d = ctl_i.entry;
        end
      end
      CMD_CANCEL: begin
        if (hit_o) begin
          entry_d = right_i;
        end
      end
      CMD_POP: begin
        entry_d = right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== sv/deadline_sorted_timer_queue_unit.sv =====
// Deadline-sorted timer queue: a chain of DEPTH cells kept in deadline order.
// Insert, cancel and an empty tick each give one registered result word.
// A tick that pops n entries gives n words on consecutive cycles, one per ST_POP
// state; busy is high in ST_RUN and in each ST_POP state. The receiver cannot
// stall; a new request is taken only in ST_IDLE, once the last one is through.
// Reset empties the queue; slots are undefined.
module deadline_sorted_timer_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [dstq_pkg::REQ_W-1:0]    req_type_i,
  input  logic [dstq_pkg::DL_W-1:0]     deadline_i,
  input  logic [dstq_pkg::DL_W-1:0]     now_time_i,
  input  logic [dstq_pkg::ID_W-1:0]     entry_id_i,
  input  logic [dstq_pkg::DEST_W-1:0]   dest_i,
  input  logic                          kind_i,
  input  logic                          lost_i,
  output logic                          result_valid_o,
  output logic [dstq_pkg::STAT_W-1:0]   status_o,
  output logic [dstq_pkg::ID_W-1:0]     out_id_o,
  output logic [dstq_pkg::DEST_W-1:0]   out_dest_o,
  output logic                          out_kind_o,
  output logic                          out_lost_o,
  output logic                          last_o,
  output logic [dstq_pkg::OCC_W-1:0]    occupancy_o
);
  import dstq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_POP  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       left_q, left_d;
  logic [CW-1:0]       fin_q, fin_d;
  logic [REQ_W-1:0]    req_q;
  logic [DL_W-1:0]     now_q;
  entry_t              new_q;

  logic                res_valid_q, res_valid_d;
  logic [STAT_W-1:0]   res_status_q, res_status_d;
  entry_t              res_entry_q, res_entry_d;
  logic                res_last_q, res_last_d;
  logic [CW-1:0]       res_occ_q, res_occ_d;

  ctl_t                ctl;
  entry_t              ent     [DEPTH];
  entry_t              left_c  [DEPTH];
  entry_t              right_c [DEPTH];
  logic [DEPTH-1:0]    le;
  logic [DEPTH:0]      le_lo;
  logic [DEPTH:0]      le_hi;
  logic [DEPTH:0]      boundary;
  logic [DEPTH:0]      hit_c;
  logic [CW-1:0]       pos_c;
  logic [CW-1:0]       due_n;
  logic                accept;
  logic                full;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign full   = (count_q == CW'(DEPTH));

  always_comb begin
    ctl.cmd   = CMD_NONE;
    ctl.key   = (req_q == REQ_TICK) ? now_q : new_q.deadline;
    ctl.entry = new_q;
    if (state_q == ST_RUN) begin
      if (req_q == REQ_INSERT && !full) begin
        ctl.cmd = CMD_INSERT;
      end else if (req_q == REQ_CANCEL) begin
        ctl.cmd = CMD_CANCEL;
      end
    end else if (state_q == ST_POP) begin
      ctl.cmd = CMD_POP;
    end
  end

  assign hit_c[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_c[g] = new_q;
    end else begin : g_body
      assign left_c[g] = ent[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_c[g] = ent[g];
    end else begin : g_inner
      assign right_c[g] = ent[g+1];
    end

    dstq_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occupied_i (CW'(g) < count_q),
      .le_prev_i  (le_lo[g]),
      .hit_prev_i (hit_c[g]),
      .left_i     (left_c[g]),
      .right_i    (right_c[g]),
      .entry_o    (ent[g]),
      .le_o       (le[g]),
      .hit_o      (hit_c[g+1])
    );
  end

  // le is a run of ones from the head: the boundary gives the due count
  assign le_lo    = {le, 1'b1};
  assign le_hi    = {1'b0, le};
  assign boundary = le_lo & ~le_hi;

  always_comb begin
    pos_c = '0;
    for (int i = 0; i <= DEPTH; i++) begin
      if (boundary[i]) begin
        pos_c = pos_c | CW'(i);
      end
    end
    if (int'(pos_c) > MAXOUT) begin
      due_n = CW'(MAXOUT);
    end else begin
      due_n = pos_c;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    left_d       = left_q;
    fin_d        = fin_q;
    res_valid_d  = 1'b0;
    res_status_d = STAT_OK;
    res_entry_d  = '0;
    res_last_d   = 1'b1;
    res_occ_d    = count_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_IDLE;
        case (req_q)
          REQ_INSERT: begin
            res_valid_d = 1'b1;
            if (full) begin
              res_status_d = STAT_FULL;
            end else begin
              count_d   = count_q + 1'b1;
              res_occ_d = count_q + 1'b1;
            end
          end
          REQ_CANCEL: begin
            res_valid_d = 1'b1;
            if (hit_c[DEPTH]) begin
              count_d   = count_q - 1'b1;
              res_occ_d = count_q - 1'b1;
            end else begin
              res_status_d = STAT_NOT_FOUND;
            end
          end
          REQ_TICK: begin
            if (due_n == '0) begin
              res_valid_d  = 1'b1;
              res_status_d = STAT_NONE_DUE;
            end else begin
              left_d  = due_n;
              fin_d   = count_q - due_n;
              state_d = ST_POP;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_POP: begin
        // emit the head and advance the chain by one slot
        res_valid_d  = 1'b1;
        res_status_d = STAT_EXPIRED;
        res_entry_d  = ent[0];
        res_last_d   = (left_q == CW'(1));
        res_occ_d    = fin_q;
        count_d      = count_q - 1'b1;
        left_d       = left_q - 1'b1;
        if (left_q == CW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q        <= fin_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    res_last_q   <= res_last_d;
    res_occ_q    <= res_occ_d;
    if (accept) begin
      req_q          <= req_type_i;
      now_q          <= now_time_i;
      new_q.deadline <= deadline_i;
      new_q.id       <= entry_id_i;
      new_q.dest     <= dest_i;
      new_q.kind     <= kind_i;
      new_q.lost     <= lost_i;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign out_id_o       = res_entry_q.id;
  assign out_dest_o     = res_entry_q.dest;
  assign out_kind_o     = res_entry_q.kind;
  assign out_lost_o     = res_entry_q.lost;
  assign last_o         = res_last_q;
  assign occupancy_o    = OCC_W'(res_occ_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP |=> count_q == CW'($past(count_q) - 1'b1))
    else $error("pop did not remove one entry");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o && status_o == STAT_EXPIRED)
    else $error("expiry burst broken before last word");

  a_quiet_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && $past(state_q) == ST_IDLE |=> !result_valid_o)
    else $error("word emitted with no request at work");

  a_full_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && req_q == REQ_INSERT && full
      |=> count_q == CW'(DEPTH) && status_o == STAT_FULL)
    else $error("insert into full queue changed state");

endmodule

// ===== bench/deadline_sorted_timer_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for deadline_sorted_timer_queue_unit: directed, full-table
// and random traffic. Predicts every result word from its own sorted table.
// Depends on dstq_pkg and the unit's RTL.
module deadline_sorted_timer_queue_unit_tb;
  import dstq_pkg::*;

  localparam int DEPTH = 16;
  localparam int LIMIT = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [DL_W-1:0] DL_MAX = '1;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [DEST_W-1:0] dest;
    logic              kind;
    logic              lost;
    logic              last;
    logic [OCC_W-1:0]  occupancy;
  } reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [REQ_W-1:0]    req_type_i = REQ_TICK;
  logic [DL_W-1:0]     deadline_i = '0;
  logic [DL_W-1:0]     now_time_i = '0;
  logic [ID_W-1:0]     entry_id_i = '0;
  logic [DEST_W-1:0]   dest_i = '0;
  logic                kind_i = 1'b0;
  logic                lost_i = 1'b0;
  logic                result_valid_o;
  logic [STAT_W-1:0]   status_o;
  logic [ID_W-1:0]     out_id_o;
  logic [DEST_W-1:0]   out_dest_o;
  logic                out_kind_o;
  logic                out_lost_o;
  logic                last_o;
  logic [OCC_W-1:0]    occupancy_o;

  // shadow of the queue contents, kept in deadline order
  entry_t      shadow_q[DEPTH];
  int unsigned shadow_count = 0;
  reply_t      pending_replies[$];
  int          errors = 0;
  int          cycles = 0;
  logic [DL_W-1:0] wall_time = 48'd1000;

  deadline_sorted_timer_queue_unit #(.DEPTH(DEPTH)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic reply_t make_reply(logic [STAT_W-1:0] status, entry_t e, logic last,
                                        int unsigned occ);
    reply_t r;
    r.status    = status;
    r.id        = e.id;
    r.dest      = e.dest;
    r.kind      = e.kind;
    r.lost      = e.lost;
    r.last      = last;
    r.occupancy = occ[OCC_W-1:0];
    return r;
  endfunction

  // advance the shadow queue by one request and queue up the words it yields
  task automatic predict_queue_step(logic [REQ_W-1:0] req, entry_t ne, logic [DL_W-1:0] now);
    entry_t      blank;
    int unsigned pos;
    int unsigned n;
    bit          hit;
    blank = '0;
    case (req)
      REQ_INSERT: begin
        if (shadow_count >= DEPTH) begin
          pending_replies.push_back(make_reply(STAT_FULL, blank, 1'b1, shadow_count));
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_q[pos].deadline <= ne.deadline) pos++;
          for (int i = shadow_count; i > pos; i--) shadow_q[i] = shadow_q[i-1];
          shadow_q[pos] = ne;
          shadow_count++;
          pending_replies.push_back(make_reply(STAT_OK, blank, 1'b1, shadow_count));
        end
      end
      REQ_CANCEL: begin
        hit = 1'b0;
        for (int i = 0; i < shadow_count; i++) begin
          if (!hit && shadow_q[i].kind && shadow_q[i].dest == ne.dest) begin
            hit = 1'b1;
            pos = i;
          end
        end
        if (hit) begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_q[i] = shadow_q[i+1];
          shadow_count--;
          pending_replies.push_back(make_reply(STAT_OK, blank, 1'b1, shadow_count));
        end else begin
          pending_replies.push_back(make_reply(STAT_NOT_FOUND, blank, 1'b1, shadow_count));
        end
      end
      REQ_TICK: begin
        n = 0;
        while (n < shadow_count && n < MAXOUT && shadow_q[n].deadline <= now) n++;
        if (n == 0) begin
          pending_replies.push_back(make_reply(STAT_NONE_DUE, blank, 1'b1, shadow_count));
        end else begin
          for (int i = 0; i < n; i++)
            pending_replies.push_back(make_reply(STAT_EXPIRED, shadow_q[i], i + 1 == n,
                                                 shadow_count - n));
          for (int i = 0; i + n < shadow_count; i++) shadow_q[i] = shadow_q[i+n];
          shadow_count -= n;
        end
      end
      default: ;
    endcase
  endtask

  // present one word and hold it until the unit takes it; start stays high on return
  task automatic send_word(logic [REQ_W-1:0] req, logic [DL_W-1:0] dl, logic [DL_W-1:0] now,
                           logic [ID_W-1:0] id, logic [DEST_W-1:0] dest, logic kind,
                           logic lost);
    entry_t e;
    req_type_i <= req;
    deadline_i <= dl;
    now_time_i <= now;
    entry_id_i <= id;
    dest_i     <= dest;
    kind_i     <= kind;
    lost_i     <= lost;
    start_i    <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    e.deadline = dl;
    e.id       = id;
    e.dest     = dest;
    e.kind     = kind;
    e.lost     = lost;
    predict_queue_step(req, e, now);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_replies();
    start_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (act !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    reply_t exp;
    if (rst_ni && result_valid_o !== 1'b0) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result word: status %0d id %0h", status_o, out_id_o);
        errors++;
      end else begin
        exp = pending_replies.pop_front();
        check_field("status", exp.status, status_o);
        check_field("out_id", exp.id, out_id_o);
        check_field("out_dest", exp.dest, out_dest_o);
        check_field("out_kind", exp.kind, out_kind_o);
        check_field("out_lost", exp.lost, out_lost_o);
        check_field("last", exp.last, last_o);
        check_field("occupancy", exp.occupancy, occupancy_o);
      end
    end
  end

  function automatic logic [DL_W-1:0] rand48();
    return DL_W'({$urandom, $urandom});
  endfunction

  task automatic test_directed();
    send_word(REQ_TICK, DL_MAX, '0, 16'hffff, 4'hf, 1'b1, 1'b1);        // empty tick
    send_word(REQ_CANCEL, '0, DL_MAX, '0, 4'd5, 1'b1, 1'b0);            // cancel on empty
    send_word(REQ_INSERT, DL_MAX, '0, 16'hffff, 4'hf, 1'b1, 1'b1);
    send_word(REQ_INSERT, '0, DL_MAX, 16'h0000, 4'h0, 1'b0, 1'b0);
    send_word(REQ_INSERT, 48'd100, '0, 16'h0001, 4'h3, 1'b1, 1'b0);
    // equal deadlines go behind earlier ones
    send_word(REQ_INSERT, 48'd100, '0, 16'h0002, 4'h3, 1'b1, 1'b1);
    send_word(REQ_INSERT, 48'd100, '0, 16'h0003, 4'h3, 1'b0, 1'b1);
    send_word(REQ_UNUSED, rand48(), rand48(), 16'h5a5a, 4'ha, 1'b1, 1'b1);
    send_word(REQ_CANCEL, '0, '0, '0, 4'h3, 1'b0, 1'b0);
    send_word(REQ_CANCEL, '0, '0, '0, 4'h9, 1'b1, 1'b0);
    send_word(REQ_CANCEL, '0, '0, '0, 4'h0, 1'b1, 1'b0);              // message only, miss
    send_word(REQ_TICK, '0, 48'd99, '0, '0, 1'b0, 1'b0);
    send_word(REQ_TICK, '0, 48'd99, '0, '0, 1'b0, 1'b0);
    send_word(REQ_TICK, '0, 48'd100, '0, '0, 1'b0, 1'b0);
    send_word(REQ_TICK, '0, DL_MAX - 1, '0, '0, 1'b0, 1'b0);
    send_word(REQ_TICK, '0, DL_MAX, '0, '0, 1'b0, 1'b0);
    send_word(REQ_TICK, '0, DL_MAX, '0, '0, 1'b0, 1'b0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i <= DEPTH; i++)
      send_word(REQ_INSERT, wall_time + $urandom_range(0, 40), rand48(), ID_W'($urandom),
                DEST_W'($urandom), 1'($urandom), 1'($urandom));
    send_word(REQ_TICK, '0, wall_time + 20, '0, '0, 1'b0, 1'b0);
    send_word(REQ_TICK, '0, DL_MAX, '0, '0, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(int words);
    int          sent;
    int          burst;
    int          pick;
    logic [REQ_W-1:0]  req;
    logic [DL_W-1:0]   dl;
    logic [DL_W-1:0]   now;
    logic [DEST_W-1:0] dest;
    sent  = 0;
    burst = $urandom_range(1, 12);
    while (sent < words) begin
      pick = $urandom_range(0, 99);
      req  = pick < 45 ? REQ_INSERT : pick < 65 ? REQ_CANCEL : pick < 96 ? REQ_TICK
                                                                        : REQ_UNUSED;
      case ($urandom_range(0, 9))
        0:       dl = '0;
        1:       dl = DL_MAX;
        2:       dl = rand48();
        default: dl = wall_time + $urandom_range(0, 300);
      endcase
      case ($urandom_range(0, 19))
        0:       now = DL_MAX;
        1, 2:    now = rand48();
        default: begin
          wall_time = wall_time + $urandom_range(0, 80);
          now = wall_time;
        end
      endcase
      dest = DEST_W'($urandom);
      // aim half the cancels at a held entry
      if (req == REQ_CANCEL && shadow_count > 0 && $urandom_range(0, 1))
        dest = shadow_q[$urandom_range(0, shadow_count - 1)].dest;
      send_word(req, dl, now, ID_W'($urandom), dest, 1'($urandom), 1'($urandom));
      if (req != REQ_UNUSED) sent++;
      burst--;
      if (burst == 0) begin
        hold_off($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    hold_off(3);
    test_full_table();
    test_random_traffic(200);
    wait_all_replies();
    test_random_traffic(200);
    wait_all_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== deadline_sorted_timer_queue_unit.f =====
sv/dstq_pkg.sv
sv/dstq_cell.sv
sv/deadline_sorted_timer_queue_unit.sv
bench/deadline_sorted_timer_queue_unit_tb.sv
